>>> src/lzwd_pkg.sv
// Shared types and constants of the LZW variable-width decoder.
package lzwd_pkg;

  localparam logic [8:0] CODE_CLEAR = 9'h100;
  localparam logic [8:0] CODE_END   = 9'h101;
  localparam logic [8:0] CODE_FIRST = 9'h102;
  localparam int unsigned MIN_WIDTH = 9;

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } dec_status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_APPEND,
    OP_ERR,
    OP_DONE,
    OP_CLEAR,
    OP_LIT,
    OP_WSTART,
    OP_KSTART,
    OP_WSTEP,
    OP_PUSHF,
    OP_KWFIX,
    OP_FIN,
    OP_POP,
    OP_POPD,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic req_pull;
    logic run;
    logic ended;
    logic depth_zero;
    logic cap_reached;
    logic pop_last;
    logic short_bits;
    logic overflow;
    logic code_end;
    logic code_clear;
    logic code_ge_clear;
    logic code_lt_first;
    logic code_lt_nfc;
    logic code_eq_nfc;
    logic prev_lt_first;
    logic prefix_lt_first;
    logic prev_seen;
    logic kw;
    logic out_free;
  } dp_status_t;

endpackage

>>> src/lzwd_datapath.sv
// Datapath: bit buffer, dictionary and stack memories, counters and output register.
module lzwd_datapath #(
  parameter int MAX_CODE_WIDTH = 13,
  parameter int DICT_DEPTH     = 8192,
  parameter int MAX_PIXELS     = 524288
) (
  input  logic              clk,
  input  logic              rst,
  input  lzwd_pkg::dp_cmd_t cmd,
  output lzwd_pkg::dp_status_t stat,
  input  logic              in_type,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              cfg_valid,
  input  logic [19:0]       cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_pixel,
  output logic              out_pixel_valid,
  output logic              out_pixel_last,
  output logic              out_need_byte,
  output logic [1:0]        out_status
);
  import lzwd_pkg::*;

  localparam int CODE_W = MAX_CODE_WIDTH;
  localparam int BUF    = MAX_CODE_WIDTH + 7;
  localparam int BW     = $clog2(BUF + 1);
  localparam int WW     = $clog2(MAX_CODE_WIDTH + 1);
  localparam int NW     = $clog2(DICT_DEPTH + 1);
  localparam int PW     = (NW > CODE_W + 1) ? NW : CODE_W + 1;
  localparam int AW     = $clog2(DICT_DEPTH);
  localparam int SD     = DICT_DEPTH + 2;
  localparam int SW     = $clog2(SD + 1);
  localparam int SAW    = $clog2(SD);
  localparam int EW     = $clog2(MAX_PIXELS + 1);
  localparam int CW     = (EW > 20) ? EW : 20;
  localparam int RW     = (CW > SW) ? CW : SW;
  localparam int DW     = CODE_W + 8;

  logic [DW-1:0]     dict [DICT_DEPTH];
  logic [7:0]        stk  [SD];
  logic [DW-1:0]     dict_dout;
  logic [7:0]        stk_dout;

  logic [19:0]       pix_limit;
  logic [BUF-1:0]    bit_buffer;
  logic [BW-1:0]     bit_count;
  logic [WW-1:0]     width_now;
  logic [NW-1:0]     next_free;
  logic [CODE_W-1:0] last_code;
  logic [CODE_W-1:0] cur_code;
  logic [CODE_W-1:0] wcode;
  logic [7:0]        first;
  logic              prev_seen;
  logic              kw;
  logic [SW-1:0]     sp;
  logic [SW-1:0]     base;
  logic [EW-1:0]     emitted;
  dec_status_t       status;
  logic              ended;
  logic              req_pull;
  logic [7:0]        req_byte;
  logic              req_last;
  logic [7:0]        res_pix;
  logic              res_valid;
  logic              res_last;

  logic [CODE_W-1:0] peek;
  logic [CODE_W-1:0] mask;
  logic [CODE_W-1:0] prefix;
  logic [CW-1:0]     cap;
  logic [CW-1:0]     rem;
  logic [CW-1:0]     emitted_w;
  logic [AW-1:0]     dict_raddr;
  logic              dict_we;
  logic              stk_we;
  logic [SAW-1:0]    stk_waddr;
  logic [7:0]        stk_wdata;
  logic [NW-1:0]     nfc_inc;

  assign mask      = {CODE_W{1'b1}} >> (CODE_W - int'(width_now));
  assign peek      = bit_buffer[CODE_W-1:0] & mask;
  assign prefix    = dict_dout[DW-1:8];
  assign emitted_w = CW'(emitted);
  assign cap       = (CW'(pix_limit) > CW'(MAX_PIXELS)) ? CW'(MAX_PIXELS) : CW'(pix_limit);
  assign rem       = cap - emitted_w;
  assign nfc_inc   = next_free + NW'(1);

  always_comb begin
    stat.req_pull        = req_pull;
    stat.run             = (status == ST_RUN);
    stat.ended           = ended;
    stat.depth_zero      = (sp == base);
    stat.cap_reached     = (emitted_w >= cap);
    stat.pop_last        = (emitted_w + CW'(1) >= cap);
    stat.short_bits      = (bit_count < BW'(width_now));
    stat.overflow        = ((BW + 1)'(bit_count) + (BW + 1)'(8) > (BW + 1)'(BUF));
    stat.code_end        = (PW'(peek) == PW'(CODE_END));
    stat.code_clear      = (PW'(peek) == PW'(CODE_CLEAR));
    stat.code_ge_clear   = (PW'(peek) >= PW'(CODE_CLEAR));
    stat.code_lt_first   = (PW'(peek) < PW'(CODE_FIRST));
    stat.code_lt_nfc     = (PW'(peek) < PW'(next_free));
    stat.code_eq_nfc     = (PW'(peek) == PW'(next_free));
    stat.prev_lt_first   = (PW'(last_code) < PW'(CODE_FIRST));
    stat.prefix_lt_first = (PW'(prefix) < PW'(CODE_FIRST));
    stat.prev_seen       = prev_seen;
    stat.kw              = kw;
    stat.out_free        = !out_valid || out_ready;
  end

  always_comb begin
    case (cmd.op)
      OP_WSTART: dict_raddr = AW'(peek);
      OP_KSTART: dict_raddr = AW'(last_code);
      default:   dict_raddr = AW'(prefix);
    endcase
  end

  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = SAW'(sp);
    stk_wdata = wcode[7:0];
    case (cmd.op)
      OP_LIT: begin
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = peek[7:0];
      end
      OP_WSTEP: begin
        stk_we    = 1'b1;
        stk_wdata = dict_dout[7:0];
      end
      OP_PUSHF: begin
        stk_we = 1'b1;
      end
      OP_KWFIX: begin
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = first;
      end
      default: stk_we = 1'b0;
    endcase
  end

  assign dict_we = (cmd.op == OP_FIN) && prev_seen && (PW'(next_free) < PW'(DICT_DEPTH));

  always_ff @(posedge clk) begin
    dict_dout <= dict[dict_raddr];
    if (dict_we) begin
      dict[AW'(next_free)] <= {last_code, first};
    end
  end

  always_ff @(posedge clk) begin
    stk_dout <= stk[SAW'(sp - SW'(1))];
    if (stk_we) begin
      stk[stk_waddr] <= stk_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_limit   <= 20'd1;
      bit_buffer  <= '0;
      bit_count   <= '0;
      width_now   <= WW'(MIN_WIDTH);
      next_free   <= NW'(CODE_FIRST);
      last_code   <= '0;
      prev_seen   <= 1'b0;
      kw          <= 1'b0;
      sp          <= '0;
      base        <= '0;
      emitted     <= '0;
      status      <= ST_RUN;
      ended       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        pix_limit <= cfg_data;
      end
      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_ACCEPT: begin
          req_pull  <= in_type;
          req_byte  <= in_byte;
          req_last  <= in_last;
          res_pix   <= '0;
          res_valid <= 1'b0;
          res_last  <= 1'b0;
        end
        OP_APPEND: begin
          bit_buffer <= bit_buffer | (BUF'(req_byte) << bit_count);
          bit_count  <= bit_count + BW'(8);
          ended      <= req_last;
        end
        OP_ERR:  status <= ST_ERR;
        OP_DONE: status <= ST_DONE;
        OP_CLEAR: begin
          bit_buffer <= bit_buffer >> width_now;
          bit_count  <= bit_count - BW'(width_now);
          width_now  <= WW'(MIN_WIDTH);
          next_free  <= NW'(CODE_FIRST);
          prev_seen  <= 1'b0;
        end
        OP_LIT: begin
          bit_buffer <= bit_buffer >> width_now;
          bit_count  <= bit_count - BW'(width_now);
          cur_code   <= peek;
          first      <= peek[7:0];
          sp         <= SW'(1);
        end
        OP_WSTART: begin
          bit_buffer <= bit_buffer >> width_now;
          bit_count  <= bit_count - BW'(width_now);
          cur_code   <= peek;
          wcode      <= peek;
          sp         <= '0;
          kw         <= 1'b0;
        end
        OP_KSTART: begin
          bit_buffer <= bit_buffer >> width_now;
          bit_count  <= bit_count - BW'(width_now);
          cur_code   <= peek;
          wcode      <= last_code;
          sp         <= SW'(1);
          kw         <= 1'b1;
        end
        OP_WSTEP: begin
          sp    <= sp + SW'(1);
          wcode <= prefix;
        end
        OP_PUSHF: begin
          sp    <= sp + SW'(1);
          first <= wcode[7:0];
        end
        OP_FIN: begin
          base      <= (RW'(sp) > RW'(rem)) ? SW'(RW'(sp) - RW'(rem)) : '0;
          last_code <= cur_code;
          prev_seen <= 1'b1;
          if (dict_we) begin
            next_free <= nfc_inc;
            if ((int'(width_now) < MAX_CODE_WIDTH) &&
                (PW'(nfc_inc) == (PW'(1) << width_now))) begin
              width_now <= width_now + WW'(1);
            end
          end
        end
        OP_POP: sp <= sp - SW'(1);
        OP_POPD: begin
          res_pix   <= stk_dout;
          res_valid <= 1'b1;
          emitted   <= emitted + EW'(1);
          if (stat.pop_last) begin
            res_last <= 1'b1;
            sp       <= base;
            status   <= ST_DONE;
          end
        end
        OP_EMIT: begin
          out_pixel       <= res_pix;
          out_pixel_valid <= res_valid;
          out_pixel_last  <= res_last;
          out_need_byte   <= (status == ST_RUN) && (sp == base) && !ended;
          out_status      <= status;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> src/lzwd_controller.sv
// Controller: sequences byte appends, code decoding, chain walks, pops and result hand-off.
module lzwd_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lzwd_pkg::dp_status_t stat,
  output lzwd_pkg::dp_cmd_t    cmd
);
  import lzwd_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ITEM  = 9'b000000010,
    S_DEC   = 9'b000000100,
    S_WALK  = 9'b000001000,
    S_PUSHF = 9'b000010000,
    S_KW    = 9'b000100000,
    S_FIN   = 9'b001000000,
    S_POPD  = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_ACCEPT;
          state_next = S_ITEM;
        end
      end
      S_ITEM: begin
        state_next = S_EMIT;
        if (!stat.req_pull) begin
          if (stat.run && !stat.ended) begin
            if (stat.overflow) begin
              cmd.op = OP_ERR;
            end else begin
              cmd.op     = OP_APPEND;
              state_next = S_DEC;
            end
          end
        end else if (stat.run && !stat.depth_zero) begin
          cmd.op     = OP_POP;
          state_next = S_POPD;
        end
      end
      S_POPD: begin
        cmd.op     = OP_POPD;
        state_next = stat.pop_last ? S_EMIT : S_DEC;
      end
      S_DEC: begin
        state_next = S_EMIT;
        if (stat.run && stat.depth_zero) begin
          if (stat.cap_reached) begin
            cmd.op = OP_DONE;
          end else if (stat.short_bits) begin
            if (stat.ended) begin
              cmd.op = OP_ERR;
            end
          end else if (stat.code_end) begin
            cmd.op = OP_ERR;
          end else if (stat.code_clear) begin
            cmd.op     = OP_CLEAR;
            state_next = S_DEC;
          end else if (!stat.prev_seen) begin
            if (stat.code_ge_clear) begin
              cmd.op = OP_ERR;
            end else begin
              cmd.op     = OP_LIT;
              state_next = S_FIN;
            end
          end else if (stat.code_lt_nfc) begin
            cmd.op     = OP_WSTART;
            state_next = stat.code_lt_first ? S_PUSHF : S_WALK;
          end else if (stat.code_eq_nfc) begin
            cmd.op     = OP_KSTART;
            state_next = stat.prev_lt_first ? S_PUSHF : S_WALK;
          end else begin
            cmd.op = OP_ERR;
          end
        end
      end
      S_WALK: begin
        cmd.op     = OP_WSTEP;
        state_next = stat.prefix_lt_first ? S_PUSHF : S_WALK;
      end
      S_PUSHF: begin
        cmd.op     = OP_PUSHF;
        state_next = stat.kw ? S_KW : S_FIN;
      end
      S_KW: begin
        cmd.op     = OP_KWFIX;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.op     = OP_FIN;
        state_next = S_DEC;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> src/lzw_variable_width_decoder.sv
// Top level of the streaming GIF-style LZW decoder (9 to MAX_CODE_WIDTH bit codes).
//
// Input channel s_*: each word is either a compressed byte (s_tuser 0, byte in
// s_tdata, s_tlast on the final byte) or a pixel pull (s_tuser 1). Every input
// word yields exactly one result word on m_*: pixel, pixel_valid, pixel_last,
// need_byte and decoder status after that word.
// cfg_*: write of the pixel limit, taken only while the block is idle.
// Words are handled one at a time. A pull that pops a pixel runs the pop and
// pop-data steps, then the hand-off step; an empty pull or an ignored byte
// goes straight to hand-off; a byte taken into the buffer is appended, then
// each code it completes is decoded, and the chain walk reads the dictionary
// memory once per cycle, one link per read. Pulls that empty the stack also
// decode the next code. The result register lets the next word be taken while
// a result waits; when a result still waits and m_tready is low, the block
// holds in its hand-off step.
// Reset: synchronous; clears the controller, counters, width to 9 and the
// output valid flag. Dictionary and stack memories need no clearing.
module lzw_variable_width_decoder #(
  parameter int MAX_CODE_WIDTH = 13,
  parameter int DICT_DEPTH     = 8192,
  parameter int MAX_PIXELS     = 524288
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic        s_tuser,   // req_type
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // pixel[7:0], need_byte[8], status[10:9], zero[15:11]
  output logic        m_tuser,   // pixel_valid
  output logic        m_tlast,   // pixel_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] cfg_data   // pixel limit
);
  import lzwd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;
  logic [7:0] pixel;
  logic       need_byte;
  logic [1:0] status;
  logic       in_ready;

  assign s_tready  = in_ready;
  assign cfg_ready = in_ready;
  assign m_tdata   = {5'd0, status, need_byte, pixel};

  lzwd_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lzwd_datapath #(
    .MAX_CODE_WIDTH (MAX_CODE_WIDTH),
    .DICT_DEPTH     (DICT_DEPTH),
    .MAX_PIXELS     (MAX_PIXELS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_type         (s_tuser),
    .in_byte         (s_tdata),
    .in_last         (s_tlast),
    .cfg_valid       (cfg_valid && in_ready),
    .cfg_data        (cfg_data),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_pixel       (pixel),
    .out_pixel_valid (m_tuser),
    .out_pixel_last  (m_tlast),
    .out_need_byte   (need_byte),
    .out_status      (status)
  );

endmodule
